/* design/tqlg_pkg.sv */
package tqlg_pkg;

   localparam int unsigned ACC_W = 32;
   localparam int unsigned MUL_W = 14;
   localparam int unsigned NUM_W = 47;
   localparam int unsigned DEN_W = 46;
   localparam int unsigned QUO_W = 29;
   localparam int unsigned CNT_W = 5;

   localparam logic [MUL_W-1:0] BPS_SCALE  = 14'd1000;
   localparam logic [MUL_W-1:0] ROUND_ADD  = 14'd9999;
   localparam logic [MUL_W-1:0] UNIT_SCALE = 14'd10000;
   localparam logic [15:0]      TP_MAX     = 16'hFFFF;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [1:0] LEVEL_OFF = 2'd0;
   localparam logic [1:0] LEVEL_MIN = 2'd1;
   localparam logic [1:0] LEVEL_MED = 2'd2;
   localparam logic [1:0] LEVEL_MAX = 2'd3;

   localparam logic [1:0] REG_LOW     = 2'd0;
   localparam logic [1:0] REG_MEDIUM  = 2'd1;
   localparam logic [1:0] REG_HIGH    = 2'd2;
   localparam logic [1:0] REG_TIMEOUT = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [15:0] byte_count;
      logic [31:0] now_ms;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  qos_level;
      logic        level_request;
      logic [15:0] throughput_units;
      logic        governor_active;
   } rsp_data_type;

   typedef struct packed {
      logic        done;
      logic [15:0] units;
   } div_rsp_type;

   function automatic logic [1:0] level_of(
      input logic [15:0] tp,
      input logic [15:0] low_thr,
      input logic [15:0] med_thr,
      input logic [15:0] high_thr
   );
      logic [1:0] lvl;
      lvl = LEVEL_OFF;
      if (high_thr != 16'd0 && tp >= high_thr) begin
         lvl = LEVEL_MAX;
      end else if (med_thr != 16'd0 && tp >= med_thr) begin
         lvl = LEVEL_MED;
      end else if (low_thr != 16'd0 && tp >= low_thr) begin
         lvl = LEVEL_MIN;
      end
      return lvl;
   endfunction

endpackage

/* design/throughput_qos_level_governor.sv */
// channel | direction | handshake             | beat
// req     | in        | req_valid / req_stall | req_data (operation, byte_count, now_ms)
// rsp     | out       | rsp_valid / rsp_stall | rsp_data (qos_level, level_request, ...)
// csr     | in        | csr_psel / csr_penable| 16-bit registers, written and read in a 32-bit word
//
// a beat that closes a window passes through the divider before its result:
// three passes of the shared multiplier and 29 steps of the restoring divider
// other beats go straight to the final step; one beat is in flight at a time
// synchronous active-high reset; no clearing pass
// req_stall is high from accept until the result beat leaves the rsp register
module throughput_qos_level_governor #(
   parameter int unsigned WINDOW_MS = 100
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tqlg_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tqlg_pkg::rsp_data_type rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RUN,
      S_DIV,
      S_FIN,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   tqlg_pkg::req_data_type item_ff, item_in;
   tqlg_pkg::rsp_data_type rsp_ff, rsp_in;
   logic                   closed_ff, closed_in;
   logic [15:0]            low_ff, low_in;
   logic [15:0]            med_ff, med_in;
   logic [15:0]            high_ff, high_in;
   logic [15:0]            tmo_ff, tmo_in;
   logic [1:0]             applied_ff, applied_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            win_start_ff, win_start_in;
   logic [15:0]            tp_ff, tp_in;
   logic                   watch_ff, watch_in;
   logic [31:0]            wait_start_ff, wait_start_in;

   logic                   csr_wr;
   logic [31:0]            elapsed;
   logic                   win_closes;
   logic                   div_start;
   tqlg_pkg::div_rsp_type  div_rsp;

   logic [15:0]            tp_v;
   logic [1:0]             exp_v;
   logic [1:0]             app_v;
   logic                   req_v;
   logic                   do_apply;
   logic [32:0]            sum_v;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign elapsed    = item_ff.now_ms - win_start_ff;
   assign win_closes = (item_ff.operation == tqlg_pkg::OP_PACKET) &&
                       (item_ff.byte_count != 16'd0) &&
                       (elapsed >= 32'(WINDOW_MS));

   tqlg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .acc     (acc_ff),
      .elapsed (elapsed),
      .div_rsp (div_rsp)
   );

   always_comb begin
      case (csr_paddr[3:2])
         tqlg_pkg::REG_LOW:     csr_prdata = {16'd0, low_ff};
         tqlg_pkg::REG_MEDIUM:  csr_prdata = {16'd0, med_ff};
         tqlg_pkg::REG_HIGH:    csr_prdata = {16'd0, high_ff};
         tqlg_pkg::REG_TIMEOUT: csr_prdata = {16'd0, tmo_ff};
         default:               csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      rsp_in        = rsp_ff;
      closed_in     = closed_ff;
      low_in        = low_ff;
      med_in        = med_ff;
      high_in       = high_ff;
      tmo_in        = tmo_ff;
      applied_in    = applied_ff;
      acc_in        = acc_ff;
      win_start_in  = win_start_ff;
      tp_in         = tp_ff;
      watch_in      = watch_ff;
      wait_start_in = wait_start_ff;
      div_start     = 1'b0;
      tp_v          = tp_ff;
      exp_v         = tqlg_pkg::LEVEL_OFF;
      app_v         = applied_ff;
      req_v         = 1'b0;
      do_apply      = 1'b0;
      sum_v         = {1'b0, acc_ff} + 33'(item_ff.byte_count);

      if (csr_wr) begin
         case (csr_paddr[3:2])
            tqlg_pkg::REG_LOW:     low_in  = csr_pwdata[15:0];
            tqlg_pkg::REG_MEDIUM:  med_in  = csr_pwdata[15:0];
            tqlg_pkg::REG_HIGH:    high_in = csr_pwdata[15:0];
            tqlg_pkg::REG_TIMEOUT: tmo_in  = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in   = req_data;
               closed_in = 1'b0;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            if (win_closes) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in  = S_FIN;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               tp_in        = div_rsp.units;
               acc_in       = '0;
               win_start_in = item_ff.now_ms;
               closed_in    = 1'b1;
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            if (item_ff.operation == tqlg_pkg::OP_PACKET) begin
               if (item_ff.byte_count != 16'd0) begin
                  if (!closed_ff) begin
                     acc_in = sum_v[32] ? '1 : sum_v[31:0];
                  end
                  if (applied_ff != tqlg_pkg::LEVEL_OFF && tp_v < low_ff) begin
                     tp_v = low_ff;
                  end
               end else begin
                  tp_v = 16'd0;
               end
               exp_v = tqlg_pkg::level_of(tp_v, low_ff, med_ff, high_ff);
               if (!watch_ff || closed_ff) begin
                  do_apply      = 1'b1;
                  watch_in      = 1'b1;
                  wait_start_in = item_ff.now_ms;
               end
            end else begin
               if (watch_ff && (item_ff.now_ms - wait_start_ff) >= {16'd0, tmo_ff}) begin
                  tp_v     = 16'd0;
                  exp_v    = tqlg_pkg::LEVEL_OFF;
                  do_apply = 1'b1;
                  watch_in = 1'b0;
               end
            end
            // level only rises, or drops straight to off
            if (do_apply && ((applied_ff < exp_v) ||
                (applied_ff != tqlg_pkg::LEVEL_OFF && exp_v == tqlg_pkg::LEVEL_OFF))) begin
               app_v = exp_v;
               req_v = 1'b1;
            end
            applied_in              = app_v;
            tp_in                   = tp_v;
            rsp_in.qos_level        = app_v;
            rsp_in.level_request    = req_v;
            rsp_in.throughput_units = tp_v;
            rsp_in.governor_active  = watch_in;
            state_in                = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      rsp_ff    <= rsp_in;
      closed_ff <= closed_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         low_ff        <= 16'd1;
         med_ff        <= 16'd50;
         high_ff       <= 16'd100;
         tmo_ff        <= 16'd500;
         applied_ff    <= tqlg_pkg::LEVEL_OFF;
         acc_ff        <= '0;
         win_start_ff  <= '0;
         tp_ff         <= '0;
         watch_ff      <= 1'b0;
         wait_start_ff <= '0;
      end else begin
         state_ff      <= state_in;
         low_ff        <= low_in;
         med_ff        <= med_in;
         high_ff       <= high_in;
         tmo_ff        <= tmo_in;
         applied_ff    <= applied_in;
         acc_ff        <= acc_in;
         win_start_ff  <= win_start_in;
         tp_ff         <= tp_in;
         watch_ff      <= watch_in;
         wait_start_ff <= wait_start_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign rsp_data  = rsp_ff;

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result beat pending");

   a_level_needs_watch: assert property (@(posedge clock) disable iff (reset)
      applied_ff != tqlg_pkg::LEVEL_OFF |-> watch_ff)
      else $error("level applied with watcher stopped");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   a_out_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FIN)
      else $error("result beat raised without final step");

endmodule

/* design/tqlg_div.sv */
module tqlg_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [31:0]                  acc,
   input  logic [31:0]                  elapsed,
   output tqlg_pkg::div_rsp_type        div_rsp
);

   typedef enum logic [2:0] {
      D_IDLE,
      D_MULA,
      D_MULB,
      D_MULC,
      D_DIV,
      D_DONE
   } div_state_type;

   div_state_type                  state_ff, state_in;
   logic [tqlg_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [tqlg_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [tqlg_pkg::NUM_W-1:0]     rem_ff, rem_in;
   logic [tqlg_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [tqlg_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [15:0]                    units_ff, units_in;

   logic [31:0]                    mul_a;
   logic [tqlg_pkg::MUL_W-1:0]     mul_b;
   logic [tqlg_pkg::DEN_W-1:0]     prod;
   logic [tqlg_pkg::NUM_W-1:0]     trial;
   logic                           fits;

   // shared multiplier
   always_comb begin
      mul_a = elapsed;
      mul_b = tqlg_pkg::UNIT_SCALE;
      case (state_ff)
         D_MULA: begin
            mul_a = acc;
            mul_b = tqlg_pkg::BPS_SCALE;
         end
         D_MULB: begin
            mul_b = tqlg_pkg::ROUND_ADD;
         end
         default: begin
            mul_b = tqlg_pkg::UNIT_SCALE;
         end
      endcase
   end

   assign prod  = tqlg_pkg::DEN_W'(mul_a) * tqlg_pkg::DEN_W'(mul_b);
   assign trial = {rem_ff[tqlg_pkg::NUM_W-2:0], num_ff[tqlg_pkg::QUO_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      units_in = units_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               state_in = D_MULA;
            end
         end
         D_MULA: begin
            // bytes times 1000
            num_in   = {1'b0, prod};
            state_in = D_MULB;
         end
         D_MULB: begin
            // add elapsed times 9999, just under one divisor, as a rounding term before the divide
            num_in   = num_ff + {1'b0, prod};
            state_in = D_MULC;
         end
         D_MULC: begin
            den_in   = prod;
            rem_in   = tqlg_pkg::NUM_W'(num_ff[tqlg_pkg::NUM_W-1:tqlg_pkg::QUO_W]);
            quo_in   = '0;
            cnt_in   = tqlg_pkg::CNT_W'(tqlg_pkg::QUO_W - 1);
            state_in = D_DIV;
         end
         D_DIV: begin
            rem_in = fits ? (trial - {1'b0, den_ff}) : trial;
            quo_in = {quo_ff[tqlg_pkg::QUO_W-2:0], fits};
            num_in = num_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               units_in = (quo_in > tqlg_pkg::QUO_W'(tqlg_pkg::TP_MAX)) ?
                          tqlg_pkg::TP_MAX : quo_in[15:0];
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      units_ff <= units_in;
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign div_rsp.done  = state_ff == D_DONE;
   assign div_rsp.units = units_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == D_DIV |-> rem_ff < {1'b0, den_ff})
      else $error("remainder not below divisor");

endmodule
